### design/brs_pkg.sv
// Shared types, constants and defaults for the binned running statistics block.
// Used by brs_arith and binned_running_statistics; depends on nothing else.
`default_nettype none
package brs_pkg;

  localparam int unsigned PlaneCountDefault  = 4;
  localparam int unsigned StatCountDefault   = 4;
  localparam int unsigned ColumnCountDefault = 64;

  localparam int unsigned SampleW = 32;
  localparam int unsigned SumW    = 64;
  localparam int unsigned CountW  = 32;
  localparam int unsigned FixW    = 48;
  localparam int unsigned WideW   = 96;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 272;

  localparam logic [FixW-1:0] FixPosMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [FixW-1:0] FixNegMax = 48'h8000_0000_0000;

  localparam logic OpAccumulate = 1'b0;
  localparam logic OpRead       = 1'b1;

  typedef struct packed {
    logic signed [SumW-1:0]    sum;
    logic [CountW-1:0]         count;
    logic signed [SampleW-1:0] max;
    logic signed [SampleW-1:0] min;
    logic                      min_seen;
    logic [SumW-1:0]           sum_squares;
  } cell_t;

  localparam cell_t CellReset = '{
    sum:         '0,
    count:       '0,
    max:         32'sh8000_0000,
    min:         32'sh7FFF_FFFF,
    min_seen:    1'b0,
    sum_squares: '0
  };

  typedef enum logic [1:0] {
    MODE_DIV,
    MODE_MUL,
    MODE_SQRT
  } brs_mode_e;

  typedef struct packed {
    logic      start;
    brs_mode_e mode;
  } brs_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MEM_RD,
    ST_ACC_WR,
    ST_RD_CHK,
    ST_MEAN,
    ST_E2,
    ST_SQUARE,
    ST_SQRT,
    ST_RATIO,
    ST_OUT
  } brs_state_e;

endpackage
`default_nettype wire

### design/binned_running_statistics.sv
// Top level of the binned running statistics block: cell store, sequencer, stream ports.
// Depends on brs_pkg and brs_arith.
//
// A sample request is accepted, its cell is read, then updated and written back. A read
// request runs the shared iterative unit: a 96-step divide for the mean, a
// 96-step divide for the mean square, a 48-step multiply, a 48-step square root and,
// if the largest sample is nonzero, a 96-step divide for the ratio, one step per cycle; an
// empty cell skips them all. After reset the store is cleared one cell per cycle, all
// PLANE_COUNT*STAT_COUNT*COLUMN_COUNT cells, before the first request is taken.
`default_nettype none
module binned_running_statistics #(
  parameter int unsigned PLANE_COUNT  = brs_pkg::PlaneCountDefault,
  parameter int unsigned STAT_COUNT   = brs_pkg::StatCountDefault,
  parameter int unsigned COLUMN_COUNT = brs_pkg::ColumnCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // sample_value[31:0], stat_index[33:32], column_index[39:34], plane_index[41:40].
  input  wire logic [brs_pkg::InDataW-1:0]   s_axis_tdata_i,
  // operation[0].
  input  wire logic                          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // total_sum[63:0], mean_value[111:64], largest_sample[143:112],
  // smallest_nonzero[175:144], std_deviation[223:176], mean_over_max[271:224].
  output logic [brs_pkg::OutDataW-1:0]       m_axis_tdata_o
);

  localparam int unsigned Cells = PLANE_COUNT * STAT_COUNT * COLUMN_COUNT;
  localparam int unsigned AddrW = (Cells > 1) ? $clog2(Cells) : 1;

  brs_pkg::cell_t mem [Cells];

  brs_pkg::brs_state_e state_q, state_d;
  logic [AddrW-1:0]    clr_q;
  logic [AddrW-1:0]    addr_q;
  logic                ok_q;
  logic                rd_q;
  logic signed [31:0]  sample_q;
  logic [63:0]         sq_q;
  brs_pkg::cell_t      cell_q;

  logic                neg_q;
  logic [47:0]         m_q;
  logic [95:0]         e2_q;
  logic [63:0]         res_sum_q;
  logic [47:0]         res_mean_q;
  logic [31:0]         res_max_q;
  logic [31:0]         res_min_q;
  logic [47:0]         res_std_q;
  logic [47:0]         res_ratio_q;

  logic                       out_valid_q;
  logic [brs_pkg::OutDataW-1:0] out_data_q;

  brs_pkg::brs_op_t   op;
  logic [95:0]        op_a;
  logic [47:0]        op_b;
  logic               ar_done;
  logic [95:0]        ar_res;

  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  brs_pkg::cell_t     mem_wdata;

  logic               in_accept;
  logic               out_load;
  logic [1:0]         in_stat, in_plane;
  logic [5:0]         in_col;
  logic               in_ok;
  logic [AddrW-1:0]   in_addr;

  logic [31:0]        sample_mag;
  logic [63:0]        sum_mag;
  logic [47:0]        mean_lim;
  logic [47:0]        m_new;
  logic [95:0]        var_val;
  logic               max_neg;
  logic [31:0]        max_mag;
  logic               ratio_neg;
  logic [47:0]        ratio_mag;
  logic               cell_empty;

  logic signed [64:0] acc_sum;
  logic [64:0]        acc_sq;
  brs_pkg::cell_t     cell_new;

  assign in_stat   = s_axis_tdata_i[33:32];
  assign in_col    = s_axis_tdata_i[39:34];
  assign in_plane  = s_axis_tdata_i[41:40];
  assign in_ok     = (32'(in_stat) < STAT_COUNT) && (32'(in_col) < COLUMN_COUNT)
                     && (32'(in_plane) < PLANE_COUNT);
  assign in_addr   = AddrW'((32'(in_plane) * STAT_COUNT + 32'(in_stat)) * COLUMN_COUNT
                            + 32'(in_col));
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load  = (state_q == brs_pkg::ST_OUT) && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = (state_q == brs_pkg::ST_IDLE);

  assign sample_mag = sample_q[31] ? (32'd0 - sample_q) : sample_q;
  assign sum_mag    = cell_q.sum[63] ? (64'd0 - cell_q.sum) : cell_q.sum;
  assign cell_empty = !ok_q || (cell_q.count == 32'd0);
  assign mean_lim   = neg_q ? brs_pkg::FixNegMax : brs_pkg::FixPosMax;
  assign m_new      = (ar_res > {48'd0, mean_lim}) ? mean_lim : ar_res[47:0];
  assign var_val    = (e2_q >= ar_res) ? (e2_q - ar_res) : (ar_res - e2_q);
  assign max_neg    = cell_q.max[31];
  assign max_mag    = max_neg ? (32'd0 - cell_q.max) : cell_q.max;
  assign ratio_neg  = neg_q ^ max_neg;
  assign ratio_mag  = (!ratio_neg && (ar_res > {48'd0, brs_pkg::FixPosMax}))
                      ? brs_pkg::FixPosMax : ar_res[47:0];

  always_comb begin
    acc_sum  = {cell_q.sum[63], cell_q.sum} + {{33{sample_q[31]}}, sample_q};
    acc_sq   = {1'b0, cell_q.sum_squares} + {1'b0, sq_q};
    cell_new = cell_q;
    if (acc_sum[64] != acc_sum[63]) begin
      cell_new.sum = acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      cell_new.sum = acc_sum[63:0];
    end
    if (cell_q.count != 32'hFFFF_FFFF) begin
      cell_new.count = cell_q.count + 32'd1;
    end
    if (sample_q > cell_q.max) begin
      cell_new.max = sample_q;
    end
    if ((sample_q != 32'sd0) && (!cell_q.min_seen || (sample_q < cell_q.min))) begin
      cell_new.min      = sample_q;
      cell_new.min_seen = 1'b1;
    end
    cell_new.sum_squares = acc_sq[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sq[63:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brs_pkg::ST_CLEAR:  if (clr_q == AddrW'(Cells - 1)) state_d = brs_pkg::ST_IDLE;
      brs_pkg::ST_IDLE:   if (in_accept) state_d = brs_pkg::ST_MEM_RD;
      brs_pkg::ST_MEM_RD: state_d = rd_q ? brs_pkg::ST_RD_CHK : brs_pkg::ST_ACC_WR;
      brs_pkg::ST_ACC_WR: state_d = brs_pkg::ST_IDLE;
      brs_pkg::ST_RD_CHK: state_d = cell_empty ? brs_pkg::ST_OUT : brs_pkg::ST_MEAN;
      brs_pkg::ST_MEAN:   if (ar_done) state_d = brs_pkg::ST_E2;
      brs_pkg::ST_E2:     if (ar_done) state_d = brs_pkg::ST_SQUARE;
      brs_pkg::ST_SQUARE: if (ar_done) state_d = brs_pkg::ST_SQRT;
      brs_pkg::ST_SQRT: begin
        if (ar_done) begin
          state_d = (cell_q.max == 32'sd0) ? brs_pkg::ST_OUT : brs_pkg::ST_RATIO;
        end
      end
      brs_pkg::ST_RATIO:  if (ar_done) state_d = brs_pkg::ST_OUT;
      brs_pkg::ST_OUT:    if (out_load) state_d = brs_pkg::ST_IDLE;
      default:            state_d = brs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op.start  = 1'b0;
    op.mode   = brs_pkg::MODE_DIV;
    op_a      = '0;
    op_b      = '0;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = cell_new;
    unique case (state_q)
      brs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = brs_pkg::CellReset;
      end
      brs_pkg::ST_ACC_WR: begin
        mem_we = ok_q;
      end
      brs_pkg::ST_RD_CHK: begin
        op.start = !cell_empty;
        op.mode  = brs_pkg::MODE_DIV;
        op_a     = {16'd0, sum_mag, 16'd0};
        op_b     = {16'd0, cell_q.count};
      end
      brs_pkg::ST_MEAN: begin
        op.start = ar_done;
        op.mode  = brs_pkg::MODE_DIV;
        op_a     = {cell_q.sum_squares, 32'd0};
        op_b     = {16'd0, cell_q.count};
      end
      brs_pkg::ST_E2: begin
        op.start = ar_done;
        op.mode  = brs_pkg::MODE_MUL;
        op_a     = {48'd0, m_q};
        op_b     = m_q;
      end
      brs_pkg::ST_SQUARE: begin
        op.start = ar_done;
        op.mode  = brs_pkg::MODE_SQRT;
        op_a     = var_val;
      end
      brs_pkg::ST_SQRT: begin
        op.start = ar_done && (cell_q.max != 32'sd0);
        op.mode  = brs_pkg::MODE_DIV;
        op_a     = {48'd0, m_q};
        op_b     = {16'd0, max_mag};
      end
      default: begin
      end
    endcase
  end

  brs_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .a_i      (op_a),
    .b_i      (op_b),
    .done_o   (ar_done),
    .result_o (ar_res)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    cell_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brs_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == brs_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q   <= in_ok ? in_addr : '0;
      ok_q     <= in_ok;
      rd_q     <= (s_axis_tuser_i == brs_pkg::OpRead);
      sample_q <= s_axis_tdata_i[31:0];
    end
    if (state_q == brs_pkg::ST_MEM_RD) begin
      sq_q <= sample_mag * sample_mag;
    end
    if (state_q == brs_pkg::ST_RD_CHK) begin
      neg_q       <= cell_q.sum[63];
      res_sum_q   <= cell_empty ? 64'd0 : cell_q.sum;
      res_max_q   <= cell_empty ? 32'd0 : cell_q.max;
      res_min_q   <= (cell_empty || !cell_q.min_seen) ? 32'd0 : cell_q.min;
      res_mean_q  <= '0;
      res_std_q   <= '0;
      res_ratio_q <= '0;
    end
    if ((state_q == brs_pkg::ST_MEAN) && ar_done) begin
      m_q        <= m_new;
      res_mean_q <= neg_q ? (48'd0 - m_new) : m_new;
    end
    if ((state_q == brs_pkg::ST_E2) && ar_done) begin
      e2_q <= ar_res;
    end
    if ((state_q == brs_pkg::ST_SQRT) && ar_done) begin
      res_std_q <= ar_res[47:0];
    end
    if ((state_q == brs_pkg::ST_RATIO) && ar_done) begin
      res_ratio_q <= ratio_neg ? (48'd0 - ratio_mag) : ratio_mag;
    end
    if (out_load) begin
      out_data_q <= {res_ratio_q, res_std_q, res_min_q, res_max_q, res_mean_q, res_sum_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
`default_nettype wire

### design/brs_arith.sv
// Shared iterative arithmetic unit: restoring divide, shift-add multiply, digit square root.
// Depends on brs_pkg.
`default_nettype none
module brs_arith (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire brs_pkg::brs_op_t         op_i,
  input  wire logic [brs_pkg::WideW-1:0] a_i,
  input  wire logic [brs_pkg::FixW-1:0]  b_i,
  output logic                          done_o,
  output logic [brs_pkg::WideW-1:0]     result_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  brs_pkg::brs_mode_e          mode_q, mode_d;
  logic [6:0]                  cnt_q, cnt_d;
  logic [brs_pkg::WideW-1:0]   z_q, z_d;
  logic [49:0]                 r_q, r_d;
  logic [brs_pkg::FixW-1:0]    root_q, root_d;
  logic [brs_pkg::FixW-1:0]    b_q, b_d;

  logic [32:0] div_rem;
  logic [48:0] mul_sum;
  logic [49:0] sq_rem;
  logic [49:0] sq_trial;

  always_comb begin
    div_rem  = {r_q[31:0], z_q[brs_pkg::WideW-1]};
    mul_sum  = {1'b0, z_q[95:48]} + (z_q[0] ? {1'b0, b_q} : 49'd0);
    sq_rem   = {r_q[47:0], z_q[95:94]};
    sq_trial = {root_q, 2'b01};

    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    z_d    = z_q;
    r_d    = r_q;
    root_d = root_q;
    b_d    = b_q;

    if (op_i.start) begin
      busy_d = 1'b1;
      mode_d = op_i.mode;
      r_d    = '0;
      root_d = '0;
      unique case (op_i.mode)
        brs_pkg::MODE_DIV: begin
          z_d   = a_i;
          b_d   = b_i;
          cnt_d = 7'd95;
        end
        brs_pkg::MODE_MUL: begin
          z_d   = {48'd0, b_i};
          b_d   = a_i[47:0];
          cnt_d = 7'd47;
        end
        default: begin
          z_d   = a_i;
          b_d   = b_i;
          cnt_d = 7'd47;
        end
      endcase
    end else if (busy_q) begin
      unique case (mode_q)
        brs_pkg::MODE_DIV: begin
          if (div_rem >= {1'b0, b_q[31:0]}) begin
            r_d = {17'd0, div_rem - {1'b0, b_q[31:0]}};
            z_d = {z_q[94:0], 1'b1};
          end else begin
            r_d = {17'd0, div_rem};
            z_d = {z_q[94:0], 1'b0};
          end
        end
        brs_pkg::MODE_MUL: begin
          z_d = {mul_sum, z_q[47:1]};
        end
        default: begin
          z_d = {z_q[93:0], 2'b00};
          if (sq_rem >= sq_trial) begin
            r_d    = sq_rem - sq_trial;
            root_d = {root_q[46:0], 1'b1};
          end else begin
            r_d    = sq_rem;
            root_d = {root_q[46:0], 1'b0};
          end
        end
      endcase
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= brs_pkg::MODE_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    r_q    <= r_d;
    root_q <= root_d;
    b_q    <= b_d;
  end

  assign done_o   = done_q;
  assign result_o = (mode_q == brs_pkg::MODE_SQRT) ? {48'd0, root_q} : z_q;

endmodule
`default_nettype wire

### dv/binned_running_statistics_test.sv
// Self-checking testbench for binned_running_statistics: drives sample and read requests
// through the stream ports and checks every finished-statistics result against its own
// predictor. Depends on brs_pkg and the block itself.
`default_nettype none
module binned_running_statistics_test;
  timeunit 1ns;
  timeprecision 1ps;
  import brs_pkg::*;

  localparam int unsigned CellTotal = PlaneCountDefault * StatCountDefault * ColumnCountDefault;
  localparam int unsigned StallLimit = 4000;

  typedef struct packed {
    logic [FixW-1:0]           mean_over_max;
    logic [FixW-1:0]           std_deviation;
    logic signed [SampleW-1:0] smallest_nonzero;
    logic signed [SampleW-1:0] largest_sample;
    logic [FixW-1:0]           mean_value;
    logic signed [SumW-1:0]    total_sum;
  } stats_t;

  class stats_scoreboard;
    logic signed [SumW-1:0]    sum_q[CellTotal];
    logic [CountW-1:0]         count_q[CellTotal];
    logic signed [SampleW-1:0] max_q[CellTotal];
    logic signed [SampleW-1:0] min_q[CellTotal];
    bit                        seen_q[CellTotal];
    logic [SumW-1:0]           sumsq_q[CellTotal];
    stats_t                    expected_q[$];
    int                        errors;
    int                        checked;

    function new();
      for (int i = 0; i < CellTotal; i++) begin
        sum_q[i] = '0;
        count_q[i] = '0;
        max_q[i] = 32'sh8000_0000;
        min_q[i] = 32'sh7FFF_FFFF;
        seen_q[i] = 1'b0;
        sumsq_q[i] = '0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function void report(string field, logic [SumW-1:0] got, logic [SumW-1:0] want);
      $display("%0t: %s is %h, expected %h", $realtime, field, got, want);
      errors++;
    endfunction

    function void fold_sample(int unsigned c, logic signed [SampleW-1:0] v);
      logic signed [SumW:0] s;
      logic [SumW-1:0] mg;
      logic [SumW:0] sq;
      s = {sum_q[c][SumW-1], sum_q[c]} + {{33{v[31]}}, v};
      if (s[SumW] != s[SumW-1]) sum_q[c] = s[SumW] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else sum_q[c] = s[SumW-1:0];
      if (count_q[c] != '1) count_q[c]++;
      if (v > max_q[c]) max_q[c] = v;
      if (v != 0 && (!seen_q[c] || v < min_q[c])) begin
        min_q[c] = v;
        seen_q[c] = 1'b1;
      end
      mg = v[31] ? (64'd0 - {{32{v[31]}}, v}) : {32'd0, v};
      sq = {1'b0, sumsq_q[c]} + {1'b0, mg * mg};
      sumsq_q[c] = sq[SumW] ? '1 : sq[SumW-1:0];
    endfunction

    function stats_t finish_cell(int unsigned c);
      stats_t r;
      logic [63:0] n, mag, qi, rem, m, q1, r1, q2, xm, rt, t;
      logic [127:0] e2, m2, vr;
      bit neg, mneg;
      logic [63:0] root;
      r = '0;
      if (count_q[c] == 0) return r;
      n = {32'd0, count_q[c]};
      neg = sum_q[c][SumW-1];
      mag = neg ? (64'd0 - sum_q[c]) : sum_q[c];
      qi = mag / n;
      rem = mag % n;
      if (qi > 64'h8000_0000) m = {16'd0, FixNegMax};
      else m = (qi << 16) | ((rem << 16) / n);
      if (!neg && m > {16'd0, FixPosMax}) m = {16'd0, FixPosMax};
      if (neg && m > {16'd0, FixNegMax}) m = {16'd0, FixNegMax};
      r.total_sum = sum_q[c];
      r.mean_value = neg ? (48'd0 - m[47:0]) : m[47:0];
      r.largest_sample = max_q[c];
      r.smallest_nonzero = seen_q[c] ? min_q[c] : '0;
      q1 = sumsq_q[c] / n;
      r1 = sumsq_q[c] % n;
      q2 = (r1 << 32) / n;
      e2 = ({64'd0, q1} << 32) | {64'd0, q2};
      m2 = {64'd0, m} * {64'd0, m};
      vr = (e2 >= m2) ? e2 - m2 : m2 - e2;
      root = '0;
      for (int b = 48; b >= 0; b--) begin
        t = root | (64'd1 << b);
        if ({64'd0, t} * {64'd0, t} <= vr) root = t;
      end
      r.std_deviation = (root > 64'hFFFF_FFFF_FFFF) ? '1 : root[47:0];
      if (max_q[c] != 0) begin
        mneg = max_q[c][31];
        xm = mneg ? (64'd0 - {{32{1'b1}}, max_q[c]}) : {32'd0, max_q[c]};
        rt = m / xm;
        if (!(neg ^ mneg) && rt > {16'd0, FixPosMax}) rt = {16'd0, FixPosMax};
        r.mean_over_max = (neg ^ mneg) ? (48'd0 - rt[47:0]) : rt[47:0];
      end
      return r;
    endfunction

    function void note_request(logic op, logic [InDataW-1:0] data);
      int unsigned c;
      c = (data[41:40] * StatCountDefault + data[33:32]) * ColumnCountDefault + data[39:34];
      if (op == OpRead) expected_q = {expected_q, finish_cell(c)};
      else fold_sample(c, data[31:0]);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      stats_t got, want;
      got = data;
      if (expected_q.size() == 0) begin
        $display("%0t: result arrived with no read request waiting", $realtime);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.total_sum != want.total_sum)
        report("total_sum", got.total_sum, want.total_sum);
      if (got.mean_value != want.mean_value)
        report("mean_value", got.mean_value, want.mean_value);
      if (got.largest_sample != want.largest_sample)
        report("largest_sample", got.largest_sample, want.largest_sample);
      if (got.smallest_nonzero != want.smallest_nonzero)
        report("smallest_nonzero", got.smallest_nonzero, want.smallest_nonzero);
      if (got.std_deviation != want.std_deviation)
        report("std_deviation", got.std_deviation, want.std_deviation);
      if (got.mean_over_max != want.mean_over_max)
        report("mean_over_max", got.mean_over_max, want.mean_over_max);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  stats_scoreboard stats_sb = new();
  bit          calm = 1'b0;
  int unsigned hold_token = 0;
  int unsigned stall_cycles = 0;
  int unsigned sample_count = 0;
  int unsigned read_count = 0;

  binned_running_statistics dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Handshakes are sampled at the falling edge, where every signal is settled.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        stats_sb.note_request(s_axis_tuser, s_axis_tdata);
        if (s_axis_tuser == OpRead) read_count++;
        else sample_count++;
      end
      if (m_axis_tvalid && m_axis_tready) stats_sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Timeout after %0d cycles without a handshake", stall_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  task automatic send_request(logic op, logic [31:0] v, logic [1:0] st, logic [5:0] col,
                              logic [1:0] pl);
    bit done;
    if (!calm) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, pl, col, st, v};
    do begin
      @(negedge clk_i);
      done = s_axis_tready;
      @(posedge clk_i);
    end while (!done);
  endtask

  task automatic send_random(int unsigned hot);
    logic [31:0] v;
    logic [1:0] st, pl;
    logic [5:0] col;
    int unsigned k;
    k = $urandom_range(3);
    case ($urandom_range(3))
      0: v = $urandom_range(200) - 100;
      1: v = $urandom;
      2: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: v = $urandom_range(65535);
    endcase
    if ($urandom_range(9) < 8) begin
      st = k[1:0];
      col = hot[5:0] + k[1:0];
      pl = hot[7:6];
    end else begin
      st = 2'($urandom);
      col = 6'($urandom);
      pl = 2'($urandom);
    end
    send_request(($urandom_range(99) < 30) ? OpRead : OpAccumulate, v, st, col, pl);
  endtask

  initial begin
    int unsigned hot;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = OpAccumulate;
    s_axis_tdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(OpRead, 32'h0, 2'd0, 6'd0, 2'd0);
    send_request(OpAccumulate, 32'h0, 2'd1, 6'd1, 2'd0);
    send_request(OpRead, 32'h0, 2'd1, 6'd1, 2'd0);
    for (int i = 0; i < 5; i++) send_request(OpAccumulate, 32'h8000_0000, 2'd3, 6'd63, 2'd3);
    send_request(OpRead, 32'h0, 2'd3, 6'd63, 2'd3);
    send_request(OpAccumulate, 32'h7FFF_FFFF, 2'd2, 6'd5, 2'd1);
    send_request(OpAccumulate, 32'h8000_0000, 2'd2, 6'd5, 2'd1);
    send_request(OpAccumulate, 32'h0000_0001, 2'd2, 6'd5, 2'd1);
    send_request(OpRead, 32'hFFFF_FFFF, 2'd2, 6'd5, 2'd1);
    send_request(OpAccumulate, 32'hFFFF_FFF0, 2'd0, 6'd9, 2'd2);
    send_request(OpAccumulate, 32'h0, 2'd0, 6'd9, 2'd2);
    send_request(OpRead, 32'h0, 2'd0, 6'd9, 2'd2);
    send_request(OpAccumulate, 32'hFFFF_FFF9, 2'd0, 6'd10, 2'd2);
    send_request(OpAccumulate, 32'hFFFF_FFFD, 2'd0, 6'd10, 2'd2);
    send_request(OpRead, 32'h0, 2'd0, 6'd10, 2'd2);
    send_request(OpAccumulate, 32'd7, 2'd1, 6'd2, 2'd3);
    send_request(OpAccumulate, 32'd3, 2'd1, 6'd2, 2'd3);
    send_request(OpRead, 32'h0, 2'd1, 6'd2, 2'd3);

    for (int i = 0; i < 630; i++) begin
      if (i % 40 == 0) hot = $urandom_range(255);
      if (i == 200) calm = 1'b1;
      if (i == 300) calm = 1'b0;
      if (i == 380) hold_token++;
      if (i == 520) begin
        s_axis_tvalid <= 1'b0;
        wait (stats_sb.expected_q.size() == 0);
        @(posedge clk_i);
      end
      if (i >= 380 && i < 400)
        send_request(OpRead, $urandom, 2'($urandom), hot[5:0] + i[1:0], hot[7:6]);
      else
        send_random(hot);
    end
    s_axis_tvalid <= 1'b0;

    wait (stats_sb.expected_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (stats_sb.expected_q.size() != 0) begin
      $display("%0d expected results never arrived", stats_sb.expected_q.size());
      stats_sb.errors++;
    end
    $display("Sent %0d sample and %0d read requests, checked %0d results.",
             sample_count, read_count, stats_sb.checked);
    $display("Covered empty cells, extreme samples, square sum clamping and output stalls.");
    if (stats_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
